/* rtl/zmap_pkg.sv */
// ----------------------------------------------------------------------------
// zmap_pkg: shared types and constants for the zone map aggregate pruner
// Operation, comparison and selectivity codes, field widths and bus widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zmap_pkg;

    // default parameter values
    localparam int              DEF_ENTRIES    = 16;
    localparam longint unsigned DEF_MAX_TUPLES = 64'd65536;

    // field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 4;
    localparam int VAL_W   = 64;
    localparam int TID_W   = 16;
    localparam int CMP_W   = 3;
    localparam int SEL_W   = 2;
    localparam int CNT_W   = 17;

    // physical entry count never exceeds what the index field can reach
    localparam int IDX_SPAN = 1 << IDX_W;

    // slave-side packing
    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 3;

    // master-side packing
    localparam int M_TDATA_W = 248;

    // operations
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
    localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd2;

    // comparisons
    localparam logic [CMP_W-1:0] CMP_EQ = 3'd0;
    localparam logic [CMP_W-1:0] CMP_LT = 3'd1;
    localparam logic [CMP_W-1:0] CMP_LE = 3'd2;
    localparam logic [CMP_W-1:0] CMP_GT = 3'd3;
    localparam logic [CMP_W-1:0] CMP_GE = 3'd4;

    // selectivity answers
    localparam logic [SEL_W-1:0] SEL_NONE    = 2'd0;
    localparam logic [SEL_W-1:0] SEL_SOME    = 2'd1;
    localparam logic [SEL_W-1:0] SEL_ALL     = 2'd2;
    localparam logic [SEL_W-1:0] SEL_UNKNOWN = 2'd3;

    // one input transaction, unpacked
    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] value;
        logic                    value_is_null;
        logic [TID_W-1:0]        tuple_tag;
        logic                    end_of_tuple;
        logic [CMP_W-1:0]        comparison;
    } zmap_item_t;

endpackage

`default_nettype wire

/* rtl/zmap_classify.sv */
// ----------------------------------------------------------------------------
// zmap_classify: predicate selectivity against an entry's value range
// Compares a literal with [min, max] and answers none, some, all or unknown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zmap_classify
    import zmap_pkg::*;
(
    input  wire logic signed [VAL_W-1:0] literal,
    input  wire logic signed [VAL_W-1:0] range_min,
    input  wire logic signed [VAL_W-1:0] range_max,
    input  wire logic                    range_valid,
    input  wire logic [CMP_W-1:0]        comparison,
    output logic [SEL_W-1:0]             selectivity
);

    logic lit_lt_min;
    logic lit_lt_max;
    logic min_lt_lit;
    logic max_lt_lit;
    logic [SEL_W-1:0] sel;

    assign lit_lt_min = literal < range_min;
    assign lit_lt_max = literal < range_max;
    assign min_lt_lit = range_min < literal;
    assign max_lt_lit = range_max < literal;

    always_comb begin
        unique case (comparison)
            CMP_EQ: sel = (lit_lt_min || max_lt_lit) ? SEL_NONE : SEL_SOME;
            CMP_LT: sel = max_lt_lit ? SEL_ALL : (!min_lt_lit ? SEL_NONE : SEL_SOME);
            CMP_LE: sel = !lit_lt_max ? SEL_ALL : (lit_lt_min ? SEL_NONE : SEL_SOME);
            CMP_GT: sel = lit_lt_min ? SEL_ALL : (!lit_lt_max ? SEL_NONE : SEL_SOME);
            CMP_GE: sel = !min_lt_lit ? SEL_ALL : (max_lt_lit ? SEL_NONE : SEL_SOME);
            default: sel = SEL_UNKNOWN;
        endcase
    end

    // an entry without any value has no range to judge
    assign selectivity = range_valid ? sel : SEL_UNKNOWN;

endmodule

`default_nettype wire

/* rtl/zone_map_aggregate_pruner.sv */
// Stages: input register, then result register; a result is valid on m_
// once its s_ transaction has been loaded into the result register.
// Throughput: one transaction per cycle while m_ is not stalled; the entry
// read, 64-bit add and range compares sit between the input and result registers.
// Reset: synchronous active-low aresetn empties both stages, marks every
// entry invalid and zeroes the tuple count; entry payloads are not reset.
// ----------------------------------------------------------------------------
// zone_map_aggregate_pruner: min/max zone map with running sums
// Keeps per-entry min/max with their tuple ids, a wrapping sum and a valid
// mark, plus a saturating tuple count; answers predicate selectivity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zone_map_aggregate_pruner
    import zmap_pkg::*;
#(
    parameter int              ENTRIES    = DEF_ENTRIES,
    parameter longint unsigned MAX_TUPLES = DEF_MAX_TUPLES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // tdata: entry_index[3:0], value[67:4], tuple_tag[83:68], comparison[86:84]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // tuser: operation[1:0], value_is_null[2]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    input  wire logic                 s_tlast,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // tdata: selectivity[1:0], range_valid[2], min_value[66:3],
    //        max_value[130:67], min_tuple[146:131], max_tuple[162:147],
    //        running_sum[226:163], tuple_count[243:227]
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready
);

    localparam int DEPTH = (ENTRIES < IDX_SPAN) ? ENTRIES : IDX_SPAN;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_TUPLES + 64'd1);
    localparam int CX    = (CW > CNT_W) ? CW : CNT_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TUPLES);

    // input stage
    zmap_item_t in_reg;
    logic       in_valid_reg;

    // entry store
    logic signed [VAL_W-1:0] min_reg   [DEPTH];
    logic signed [VAL_W-1:0] max_reg   [DEPTH];
    logic signed [VAL_W-1:0] sum_reg   [DEPTH];
    logic [TID_W-1:0]        min_t_reg [DEPTH];
    logic [TID_W-1:0]        max_t_reg [DEPTH];
    logic [DEPTH-1:0]        valid_reg;
    logic [CW-1:0]           count_reg;

    // result stage
    logic [M_TDATA_W-1:0] out_reg;
    logic                 out_valid_reg;

    logic load;
    logic in_range;
    logic [IW-1:0] e;

    logic                    rd_valid;
    logic signed [VAL_W-1:0] rd_min, rd_max, rd_sum;
    logic [TID_W-1:0]        rd_min_t, rd_max_t;

    logic                    upd;
    logic                    nw_valid;
    logic signed [VAL_W-1:0] nw_min, nw_max, nw_sum;
    logic [TID_W-1:0]        nw_min_t, nw_max_t;
    logic [CW-1:0]           count_next;
    logic [CX-1:0]           count_ext;
    logic [SEL_W-1:0]        cls_sel, sel;
    logic [M_TDATA_W-1:0]    out_next;

    assign load     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_reg.operation     <= s_tuser[1:0];
            in_reg.value_is_null <= s_tuser[2];
            in_reg.entry_index   <= s_tdata[3:0];
            in_reg.value         <= s_tdata[67:4];
            in_reg.tuple_tag     <= s_tdata[83:68];
            in_reg.comparison    <= s_tdata[86:84];
            in_reg.end_of_tuple  <= s_tlast;
        end
    end

    assign in_range = {28'd0, in_reg.entry_index} < 32'(ENTRIES);
    assign e        = in_range ? IW'(in_reg.entry_index) : '0;

    // an invalid entry reads as all zero
    always_comb begin
        rd_valid = in_range && valid_reg[e];
        rd_min   = rd_valid ? min_reg[e]   : '0;
        rd_max   = rd_valid ? max_reg[e]   : '0;
        rd_sum   = rd_valid ? sum_reg[e]   : '0;
        rd_min_t = rd_valid ? min_t_reg[e] : '0;
        rd_max_t = rd_valid ? max_t_reg[e] : '0;
    end

    zmap_classify u_classify (
        .literal     (in_reg.value),
        .range_min   (rd_min),
        .range_max   (rd_max),
        .range_valid (rd_valid),
        .comparison  (in_reg.comparison),
        .selectivity (cls_sel)
    );

    always_comb begin
        upd        = 1'b0;
        nw_valid   = rd_valid;
        nw_min     = rd_min;
        nw_max     = rd_max;
        nw_sum     = rd_sum;
        nw_min_t   = rd_min_t;
        nw_max_t   = rd_max_t;
        count_next = count_reg;
        sel        = SEL_UNKNOWN;
        unique case (in_reg.operation)
            OP_CLEAR: begin
                nw_valid   = 1'b0;
                nw_min     = '0;
                nw_max     = '0;
                nw_sum     = '0;
                nw_min_t   = '0;
                nw_max_t   = '0;
                count_next = '0;
            end
            OP_ADD: begin
                if (in_range && !in_reg.value_is_null) begin
                    upd      = 1'b1;
                    nw_valid = 1'b1;
                    nw_sum   = rd_sum + in_reg.value;
                    // strict compares keep the earlier tuple id on ties
                    if (!rd_valid || in_reg.value < rd_min) begin
                        nw_min   = in_reg.value;
                        nw_min_t = in_reg.tuple_tag;
                    end
                    if (!rd_valid || rd_max < in_reg.value) begin
                        nw_max   = in_reg.value;
                        nw_max_t = in_reg.tuple_tag;
                    end
                end
                if (in_reg.end_of_tuple && count_reg < CNT_MAX) begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_CLASSIFY: begin
                sel = cls_sel;
            end
            default: begin
            end
        endcase
    end

    assign count_ext = CX'(count_next);

    assign out_next = {
        4'd0,
        count_ext[CNT_W-1:0],
        nw_sum,
        nw_max_t,
        nw_min_t,
        nw_max,
        nw_min,
        nw_valid,
        sel
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else if (load) begin
            count_reg <= count_next;
            if (in_reg.operation == OP_CLEAR) begin
                valid_reg <= '0;
            end else if (upd) begin
                valid_reg[e] <= 1'b1;
            end
        end
        if (load && upd) begin
            min_reg[e]   <= nw_min;
            max_reg[e]   <= nw_max;
            sum_reg[e]   <= nw_sum;
            min_t_reg[e] <= nw_min_t;
            max_t_reg[e] <= nw_max_t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (load) begin
            out_reg <= out_next;
        end
    end

    assign m_tdata  = out_reg;
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/zmap_checker.sv */
// ----------------------------------------------------------------------------
// zmap_checker: port-level checks for the zone map aggregate pruner
// Watches the result stream for reset, hold and range consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zmap_checker
    import zmap_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready
);

    logic                    rv;
    logic [SEL_W-1:0]        sel;
    logic signed [VAL_W-1:0] mn;
    logic signed [VAL_W-1:0] mx;

    assign sel = m_tdata[1:0];
    assign rv  = m_tdata[2];
    assign mn  = m_tdata[66:3];
    assign mx  = m_tdata[130:67];

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // an entry with no range reports zero aggregates and an unknown answer
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !rv |-> m_tdata[226:3] == '0 && sel == SEL_UNKNOWN)
        else $error("empty entry reports data");

    // a valid range is ordered
    a_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && rv |-> !(mx < mn))
        else $error("min above max");

endmodule

bind zone_map_aggregate_pruner zmap_checker u_zmap_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

/* verif/zone_map_aggregate_pruner_test.sv */
// ----------------------------------------------------------------------------
// zone_map_aggregate_pruner_test: self-checking bench for the zone map pruner
// Streams clear, add and classify transactions into the block. A scoreboard
// keeps its own copy of the per-entry min/max/sum state and the tuple count,
// and compares every result field by field. Idling on both sides and a long
// result hold-off are included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zone_map_aggregate_pruner_test;
    import zmap_pkg::*;

    localparam logic [OP_W-1:0]  OP_RESERVED   = 2'd3;
    localparam logic [CMP_W-1:0] CMP_UNK_FIRST = 3'd5;
    localparam logic [CMP_W-1:0] CMP_UNK_LAST  = 3'd7;
    localparam logic signed [VAL_W-1:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [VAL_W-1:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 620;

    // result fields, lowest bits last
    typedef struct packed {
        logic [CNT_W-1:0]        tuple_count;
        logic signed [VAL_W-1:0] running_sum;
        logic [TID_W-1:0]        max_tuple;
        logic [TID_W-1:0]        min_tuple;
        logic signed [VAL_W-1:0] max_value;
        logic signed [VAL_W-1:0] min_value;
        logic                    range_valid;
        logic [SEL_W-1:0]        selectivity;
    } agg_report_t;

    class zone_map_scoreboard;
        logic signed [VAL_W-1:0] lo_val [DEF_ENTRIES];
        logic signed [VAL_W-1:0] hi_val [DEF_ENTRIES];
        logic signed [VAL_W-1:0] sum_val [DEF_ENTRIES];
        logic [TID_W-1:0]        lo_tid [DEF_ENTRIES];
        logic [TID_W-1:0]        hi_tid [DEF_ENTRIES];
        bit                      valid [DEF_ENTRIES];
        longint unsigned         tuples;
        agg_report_t             expected_reports [$];
        int                      mismatches;

        function new();
            clear_all();
            mismatches = 0;
        endfunction

        function void clear_all();
            for (int i = 0; i < DEF_ENTRIES; i++) begin
                lo_val[i] = '0;
                hi_val[i] = '0;
                sum_val[i] = '0;
                lo_tid[i] = '0;
                hi_tid[i] = '0;
                valid[i] = 1'b0;
            end
            tuples = 0;
        endfunction

        static function logic [SEL_W-1:0] selectivity_of(logic signed [VAL_W-1:0] lit,
                                                         logic signed [VAL_W-1:0] mn,
                                                         logic signed [VAL_W-1:0] mx,
                                                         logic [CMP_W-1:0] cmp);
            case (cmp)
                CMP_EQ: return (lit < mn || mx < lit) ? SEL_NONE : SEL_SOME;
                CMP_LT: return (mx < lit) ? SEL_ALL : (!(mn < lit) ? SEL_NONE : SEL_SOME);
                CMP_LE: return !(lit < mx) ? SEL_ALL : ((lit < mn) ? SEL_NONE : SEL_SOME);
                CMP_GT: return (lit < mn) ? SEL_ALL : (!(lit < mx) ? SEL_NONE : SEL_SOME);
                CMP_GE: return !(mn < lit) ? SEL_ALL : ((mx < lit) ? SEL_NONE : SEL_SOME);
                default: return SEL_UNKNOWN;
            endcase
        endfunction

        // fold one accepted transaction into the state and queue its report
        function void apply_item(zmap_item_t it);
            agg_report_t r;
            int e;
            e = it.entry_index;
            r.selectivity = SEL_UNKNOWN;
            case (it.operation)
                OP_CLEAR: clear_all();
                OP_ADD: begin
                    if (!it.value_is_null) begin
                        sum_val[e] = sum_val[e] + it.value;
                        if (!valid[e]) begin
                            lo_val[e] = it.value;
                            hi_val[e] = it.value;
                            lo_tid[e] = it.tuple_tag;
                            hi_tid[e] = it.tuple_tag;
                            valid[e] = 1'b1;
                        end else begin
                            // strict compares: ties keep the earlier tuple id
                            if (it.value < lo_val[e]) begin
                                lo_val[e] = it.value;
                                lo_tid[e] = it.tuple_tag;
                            end
                            if (it.value > hi_val[e]) begin
                                hi_val[e] = it.value;
                                hi_tid[e] = it.tuple_tag;
                            end
                        end
                    end
                    if (it.end_of_tuple && tuples < DEF_MAX_TUPLES)
                        tuples++;
                end
                OP_CLASSIFY: begin
                    if (valid[e])
                        r.selectivity = selectivity_of(it.value, lo_val[e], hi_val[e],
                                                       it.comparison);
                end
                default: ;
            endcase
            r.range_valid = valid[e];
            r.min_value = lo_val[e];
            r.max_value = hi_val[e];
            r.min_tuple = lo_tid[e];
            r.max_tuple = hi_tid[e];
            r.running_sum = sum_val[e];
            r.tuple_count = tuples[CNT_W-1:0];
            expected_reports.push_back(r);
        endfunction

        function void check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t MISMATCH %s: expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] bus);
            agg_report_t got;
            agg_report_t want;
            got = bus[$bits(agg_report_t)-1:0];
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t MISMATCH unexpected result %h", $time, got);
                return;
            end
            want = expected_reports.pop_front();
            check_field("selectivity", want.selectivity, got.selectivity);
            check_field("range_valid", want.range_valid, got.range_valid);
            check_field("min_value", want.min_value, got.min_value);
            check_field("max_value", want.max_value, got.max_value);
            check_field("min_tuple", want.min_tuple, got.min_tuple);
            check_field("max_tuple", want.max_tuple, got.max_tuple);
            check_field("running_sum", want.running_sum, got.running_sum);
            check_field("tuple_count", want.tuple_count, got.tuple_count);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // leftover expectations count as failures
        function int close_out();
            if (expected_reports.size() != 0) begin
                $display("MISMATCH %0d results never arrived", expected_reports.size());
                mismatches += expected_reports.size();
            end
            return mismatches;
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 s_tlast;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready;

    int unsigned send_idle_pct = 14;
    int unsigned recv_idle_pct = 50;
    int          hold_cycles = 0;
    int          cycle_count = 0;

    zone_map_scoreboard sb = new();

    zone_map_aggregate_pruner dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // result side: random backpressure, or a counted hold-off when requested
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic zmap_item_t make_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                             logic signed [VAL_W-1:0] val, logic is_null,
                                             logic [TID_W-1:0] tid, logic eot,
                                             logic [CMP_W-1:0] cmp);
        zmap_item_t it;
        it.operation = op;
        it.entry_index = idx;
        it.value = val;
        it.value_is_null = is_null;
        it.tuple_tag = tid;
        it.end_of_tuple = eot;
        it.comparison = cmp;
        return it;
    endfunction

    function automatic logic signed [VAL_W-1:0] random_value();
        longint v;
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: begin
                // narrow band so ties and boundary hits are common
                v = longint'($urandom_range(0, 100)) - 50;
                return v;
            end
            2: begin
                case ($urandom_range(0, 5))
                    0: return S64_MIN;
                    1: return S64_MAX;
                    2: return S64_MIN + 1;
                    3: return S64_MAX - 1;
                    4: return -1;
                    default: return 0;
                endcase
            end
            default: return $signed({$urandom, $urandom}) >>> $urandom_range(1, 62);
        endcase
    endfunction

    function automatic zmap_item_t random_item();
        zmap_item_t it;
        int unsigned pick;
        int e;
        it = make_item(OP_ADD, IDX_W'($urandom_range(0, IDX_SPAN - 1)), random_value(),
                       ($urandom_range(0, 4) == 0), TID_W'($urandom),
                       1'($urandom_range(0, 1)), CMP_W'($urandom_range(CMP_EQ, CMP_GE)));
        e = it.entry_index;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            it.operation = OP_CLEAR;
        end else if (pick < 4) begin
            it.operation = OP_RESERVED;
        end else if (pick >= 58) begin
            it.operation = OP_CLASSIFY;
            if ($urandom_range(0, 9) == 0)
                it.comparison = CMP_W'($urandom_range(CMP_UNK_FIRST, CMP_UNK_LAST));
            // aim literals at the current range edges
            case ($urandom_range(0, 5))
                0: it.value = sb.lo_val[e] - 1;
                1: it.value = sb.lo_val[e];
                2: it.value = sb.hi_val[e];
                3: it.value = sb.hi_val[e] + 1;
                4: it.value = (sb.lo_val[e] >>> 1) + (sb.hi_val[e] >>> 1);
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic send_item(input zmap_item_t it);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= {1'b0, it.comparison, it.tuple_tag, it.value, it.entry_index};
        s_tuser <= {it.value_is_null, it.operation};
        s_tlast <= it.end_of_tuple;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.apply_item(it);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        s_tvalid = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, ties, nulls, every comparison, bad op, clear
        send_item(make_item(OP_CLASSIFY, 0, 0, 0, 0, 0, CMP_EQ));
        send_item(make_item(OP_ADD, 0, S64_MIN, 0, 16'hFFFF, 1, CMP_GE));
        send_item(make_item(OP_ADD, 0, S64_MAX, 0, 16'h0000, 0, CMP_UNK_LAST));
        send_item(make_item(OP_ADD, 0, S64_MAX, 0, 16'h1234, 1, CMP_EQ));
        send_item(make_item(OP_ADD, 0, S64_MIN, 0, 16'h4321, 0, CMP_EQ));
        send_item(make_item(OP_ADD, 0, -1, 1, 16'hABCD, 1, CMP_EQ));
        for (int c = 0; c < 8; c++)
            send_item(make_item(OP_CLASSIFY, 0, 0, 0, 0, 0, CMP_W'(c)));
        send_item(make_item(OP_ADD, 15, 42, 0, 16'h0007, 0, CMP_EQ));
        send_item(make_item(OP_CLASSIFY, 15, 42, 0, 0, 0, CMP_EQ));
        send_item(make_item(OP_CLASSIFY, 15, 42, 0, 0, 0, CMP_GE));
        send_item(make_item(OP_CLASSIFY, 15, 42, 0, 0, 0, CMP_LT));
        send_item(make_item(OP_ADD, 15, S64_MAX, 0, 16'h8000, 1, CMP_EQ));
        send_item(make_item(OP_RESERVED, 15, S64_MIN, 1, 16'hFFFF, 1, CMP_UNK_FIRST));
        send_item(make_item(OP_CLEAR, 3, S64_MAX, 1, 16'hFFFF, 1, CMP_UNK_LAST));
        send_item(make_item(OP_CLASSIFY, 0, 0, 0, 0, 0, CMP_LE));

        repeat (PHASE_ITEMS) send_item(random_item());

        send_idle_pct = 50;
        recv_idle_pct = 14;
        repeat (PHASE_ITEMS) send_item(random_item());

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 200;  // result side stalls while input keeps coming
        repeat (PHASE_ITEMS / 2) send_item(random_item());
        drain();
        repeat (PHASE_ITEMS / 2) send_item(random_item());

        // fresh start, then a short random tail
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0, CMP_EQ));
        repeat (20) send_item(random_item());
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0, CMP_EQ));
        send_item(make_item(OP_ADD, 1, 7, 0, 16'h0001, 1, CMP_EQ));

        drain();
        repeat (4) @(posedge aclk);
        if (sb.close_out() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
